// ----- rtl/core/rmcs_pkg.sv -----
// shared types and constants of the refresh mode closest select block
// no dependencies; every other file of the block refers to this package
package rmcs_pkg;

   localparam int FIELD_W   = 32;  // width of every numerator, denominator and rate
   localparam int RATIO_W   = 17;  // width of the q0.24 tolerance ratios
   localparam int RATIO_SHIFT = 24; // fraction bits of the ratios
   localparam int TOL_W     = 25;  // widest tolerance, wide ratio times the largest rate
   localparam int MUL_STEPS = 32;  // one multiplier bit per cycle

   // 0.0005 and 0.005 as q0.24, rounded to nearest
   localparam logic [RATIO_W-1:0] CLOSE_RATIO_Q24 = 17'd8389;
   localparam logic [RATIO_W-1:0] WIDE_RATIO_Q24  = 17'd83886;

   // configuration register indexes
   localparam logic CSR_REQ_NUM = 1'b0;
   localparam logic CSR_REQ_DEN = 1'b1;

   typedef enum logic [1:0] {
      PATH_NONE  = 2'd0,
      PATH_CLOSE = 2'd1,
      PATH_WIDE  = 2'd2
   } path_type;

   // one candidate as the tiers keep it
   typedef struct packed {
      logic [FIELD_W-1:0] num;
      logic [FIELD_W-1:0] den;
      logic [FIELD_W-1:0] rate;
      logic [FIELD_W-1:0] diff;
   } best_type;

endpackage

// ----- rtl/core/rmcs_if.sv -----
// valid/ready channels of the refresh mode closest select block
// depends on rmcs_pkg for the field widths
interface rmcs_req_if;
   logic                        valid;
   logic                        ready;
   logic [rmcs_pkg::FIELD_W-1:0] candidate_numerator;
   logic [rmcs_pkg::FIELD_W-1:0] candidate_denominator;
   logic                        last_candidate;

   modport source (
      output valid, candidate_numerator, candidate_denominator, last_candidate,
      input  ready
   );
   modport sink (
      input  valid, candidate_numerator, candidate_denominator, last_candidate,
      output ready
   );
endinterface

interface rmcs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  match_path;
   logic [rmcs_pkg::FIELD_W-1:0] chosen_numerator;
   logic [rmcs_pkg::FIELD_W-1:0] chosen_denominator;
   logic [rmcs_pkg::FIELD_W-1:0] chosen_rate;
   logic [rmcs_pkg::FIELD_W-1:0] rate_difference;
   logic [rmcs_pkg::FIELD_W-1:0] requested_rate;

   modport source (
      output valid, match_path, chosen_numerator, chosen_denominator, chosen_rate,
             rate_difference, requested_rate,
      input  ready
   );
   modport sink (
      input  valid, match_path, chosen_numerator, chosen_denominator, chosen_rate,
             rate_difference, requested_rate,
      output ready
   );
endinterface

// ----- rtl/core/rmcs_div.sv -----
// bit-serial restoring divider: saturated floor(n * 2^FRAC_BITS / d), zero for d = 0
// depends on rmcs_pkg
module rmcs_div #(
   parameter int FRAC_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rmcs_pkg::FIELD_W-1:0] dividend,
   input  logic [rmcs_pkg::FIELD_W-1:0] divisor,
   output logic                         done,
   output logic [rmcs_pkg::FIELD_W-1:0] quotient
);

   localparam int W     = rmcs_pkg::FIELD_W;
   localparam int QBITS = W + FRAC_BITS;
   localparam int CNT_W = $clog2(QBITS + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [W-1:0]     num_sh_ff;
   logic [W-1:0]     den_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     q_ff;
   logic             ovf_ff;
   logic             dzero_ff;

   logic [W:0]   shifted;
   logic [W:0]   sub;
   logic         ge;
   logic [W-1:0] rem_in;

   always_comb begin
      shifted = {rem_ff, num_sh_ff[W-1]};
      ge      = shifted >= {1'b0, den_ff};
      sub     = shifted - {1'b0, den_ff};
      rem_in  = ge ? sub[W-1:0] : shifted[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QBITS);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_sh_ff <= dividend;
         den_ff    <= divisor;
         rem_ff    <= '0;
         q_ff      <= '0;
         ovf_ff    <= 1'b0;
         dzero_ff  <= (divisor == '0);
      end else if (cnt_ff != '0) begin
         num_sh_ff <= {num_sh_ff[W-2:0], 1'b0};
         rem_ff    <= rem_in;
         q_ff      <= {q_ff[W-2:0], ge};
         ovf_ff    <= ovf_ff | q_ff[W-1];
      end
   end

   assign done     = done_ff;
   assign quotient = dzero_ff ? '0 : (ovf_ff ? '1 : q_ff);

endmodule

// ----- rtl/core/rmcs_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit a cycle
// depends on rmcs_pkg
module rmcs_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rmcs_pkg::FIELD_W-1:0]   mcand,
   input  logic [rmcs_pkg::FIELD_W-1:0]   mplier,
   output logic [2*rmcs_pkg::FIELD_W-1:0] product
);

   localparam int W     = rmcs_pkg::FIELD_W;
   localparam int CNT_W = $clog2(rmcs_pkg::MUL_STEPS + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     a_ff;
   logic [W-1:0]     b_ff;
   logic [2*W-1:0]   acc_ff;
   logic [W:0]       sum;

   assign sum = {1'b0, acc_ff[2*W-1:W]} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(rmcs_pkg::MUL_STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= mcand;
         b_ff   <= mplier;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         acc_ff <= {sum, acc_ff[W-1:1]};
         b_ff   <= {1'b0, b_ff[W-1:1]};
      end
   end

   assign product = acc_ff;

endmodule

// ----- rtl/core/rmcs_tier.sv -----
// best-candidate tracker for one tolerance tier, ties go to the higher rate
// depends on rmcs_pkg
module rmcs_tier (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       judge,
   input  rmcs_pkg::best_type         cand,
   input  logic [rmcs_pkg::TOL_W-1:0] tol,
   output logic                       seen,
   output rmcs_pkg::best_type         best
);

   localparam int W = rmcs_pkg::FIELD_W;

   logic               seen_ff;
   rmcs_pkg::best_type best_ff;

   logic [W:0] d_ext;
   logic [W:0] b_ext;
   logic       in_tol;
   logic       nearer;
   logic       tie;
   logic       take;

   always_comb begin
      d_ext  = {1'b0, cand.diff};
      b_ext  = {1'b0, best_ff.diff};
      in_tol = cand.diff <= W'(tol);
      nearer = (d_ext + (W+1)'(1)) < b_ext;
      tie    = (d_ext <= b_ext + (W+1)'(1)) && (b_ext <= d_ext + (W+1)'(1));
      take   = judge && in_tol && (!seen_ff || nearer || (tie && cand.rate > best_ff.rate));
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         seen_ff <= 1'b0;
      end else if (take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         best_ff <= '0;
      end else if (take) begin
         best_ff <= cand;
      end
   end

   assign seen = seen_ff;
   assign best = best_ff;

endmodule

// ----- rtl/core/refresh_mode_closest_select.sv -----
// top level of the refresh mode closest select block
// depends on rmcs_pkg, rmcs_if, rmcs_div, rmcs_mul and rmcs_tier

// Scans a list of display modes, one candidate rate num/den per beat, and
// returns one result beat on the beat flagged last_candidate: the first
// candidate exactly equal to the requested rate, else the nearest within
// max(0.02 Hz, 0.05 %), else the nearest within 0.5 %, ties to the higher
// rate. Rates are unsigned Q(32-F).F Hz, F = RATE_FRACTION_BITS, truncated
// and saturated. One candidate is worked on at a time: req_bus.ready is low
// from acceptance while the two restoring dividers (request and candidate)
// make one quotient bit a cycle over 32 + RATE_FRACTION_BITS bits, then
// through ST_TOL_CLOSE, ST_TOL_WIDE and ST_JUDGE, and for the last beat of
// a list also in ST_EMIT, which loads the result register when it is empty
// or its beat is being taken. The exact-match cross products come from two
// shift-add multipliers that finish no later than the dividers. The request
// registers are written through csr_* and take effect from the next beat.
module refresh_mode_closest_select #(
   parameter int RATE_FRACTION_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   rmcs_req_if.sink                     req_bus,
   rmcs_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [rmcs_pkg::FIELD_W-1:0] csr_wr_data
);

   localparam int W       = rmcs_pkg::FIELD_W;
   localparam int TOL_W   = rmcs_pkg::TOL_W;
   localparam int PROD_W  = W + rmcs_pkg::RATIO_W;
   // 0.02 Hz in rate lsb, rounded
   localparam int CLOSE_FLOOR_INT = ((1 << RATE_FRACTION_BITS) * 2 + 50) / 100;
   localparam logic [TOL_W-1:0] CLOSE_FLOOR = TOL_W'(CLOSE_FLOOR_INT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_TOL_CLOSE,
      ST_TOL_WIDE,
      ST_JUDGE,
      ST_EMIT
   } state_type;

   // request registers
   logic [W-1:0] csr_num_ff;
   logic [W-1:0] csr_den_ff;

   // control and result register
   state_type    state_ff;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_path_ff;
   logic [W-1:0] rsp_num_ff;
   logic [W-1:0] rsp_den_ff;
   logic [W-1:0] rsp_rate_ff;
   logic [W-1:0] rsp_diff_ff;
   logic [W-1:0] rsp_req_ff;

   // candidate held for the length of its work
   logic [W-1:0] cand_num_ff;
   logic [W-1:0] cand_den_ff;
   logic         cand_last_ff;
   logic         rden_nz_ff;

   // rates, distance and tolerances of the candidate
   logic [W-1:0]     rr_ff;
   logic [W-1:0]     cr_ff;
   logic [W-1:0]     diff_ff;
   logic [TOL_W-1:0] tol_close_ff;
   logic [TOL_W-1:0] tol_wide_ff;

   // first exact match of the list
   logic         exact_seen_ff;
   logic [W-1:0] exact_num_ff;
   logic [W-1:0] exact_den_ff;
   logic [W-1:0] exact_rate_ff;

   logic         accept;
   logic         div_done;
   logic         div_req_done;
   logic [W-1:0] rr_q;
   logic [W-1:0] cr_q;
   logic [2*W-1:0] prod_req;
   logic [2*W-1:0] prod_cand;

   logic [rmcs_pkg::RATIO_W-1:0] tol_ratio;
   logic [W-1:0]     tol_base;
   logic [PROD_W-1:0] tol_prod;
   logic [TOL_W-1:0] tol_raw;

   rmcs_pkg::best_type cand_entry;
   rmcs_pkg::best_type close_best;
   rmcs_pkg::best_type wide_best;
   logic close_seen;
   logic wide_seen;
   logic judge_en;
   logic exact_hit;
   logic out_free;
   logic emit;

   rmcs_pkg::path_type path_in;
   logic [W-1:0] num_in;
   logic [W-1:0] den_in;
   logic [W-1:0] rate_in;
   logic [W-1:0] diff_in;
   logic [W-1:0] req_in;

   assign accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // request rate and candidate rate, side by side
   rmcs_div #(.FRAC_BITS(RATE_FRACTION_BITS)) u_div_req (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (csr_num_ff),
      .divisor  (csr_den_ff),
      .done     (div_req_done),
      .quotient (rr_q)
   );

   rmcs_div #(.FRAC_BITS(RATE_FRACTION_BITS)) u_div_cand (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_bus.candidate_numerator),
      .divisor  (req_bus.candidate_denominator),
      .done     (div_done),
      .quotient (cr_q)
   );

   // cross products for the exact test, ready no later than the dividers
   rmcs_mul u_mul_req (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (csr_num_ff),
      .mplier  (req_bus.candidate_denominator),
      .product (prod_req)
   );

   rmcs_mul u_mul_cand (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (req_bus.candidate_numerator),
      .mplier  (csr_den_ff),
      .product (prod_cand)
   );

   // one tolerance multiplier shared by ST_TOL_CLOSE and ST_TOL_WIDE
   always_comb begin
      if (state_ff == ST_TOL_CLOSE) begin
         tol_ratio = rmcs_pkg::CLOSE_RATIO_Q24;
         tol_base  = rr_q;
      end else begin
         tol_ratio = rmcs_pkg::WIDE_RATIO_Q24;
         tol_base  = rr_ff;
      end
      tol_prod = PROD_W'(tol_base) * PROD_W'(tol_ratio);
      tol_raw  = tol_prod[rmcs_pkg::RATIO_SHIFT +: TOL_W];
   end

   always_comb begin
      cand_entry.num  = cand_num_ff;
      cand_entry.den  = cand_den_ff;
      cand_entry.rate = cr_ff;
      cand_entry.diff = diff_ff;
      // unusable candidates and an empty request take no part in the tiers
      judge_en  = (state_ff == ST_JUDGE) && (cand_den_ff != '0) && (cr_ff != '0)
                  && (rr_ff != '0);
      exact_hit = (state_ff == ST_JUDGE) && !exact_seen_ff && rden_nz_ff
                  && (cand_den_ff != '0) && (prod_req == prod_cand);
      out_free  = !rsp_valid_ff || rsp_bus.ready;
      emit      = (state_ff == ST_EMIT) && out_free;
   end

   rmcs_tier u_tier_close (
      .clock (clock),
      .reset (reset),
      .clear (emit),
      .judge (judge_en),
      .cand  (cand_entry),
      .tol   (tol_close_ff),
      .seen  (close_seen),
      .best  (close_best)
   );

   rmcs_tier u_tier_wide (
      .clock (clock),
      .reset (reset),
      .clear (emit),
      .judge (judge_en),
      .cand  (cand_entry),
      .tol   (tol_wide_ff),
      .seen  (wide_seen),
      .best  (wide_best)
   );

   // result of the list, exact first, then close, then wide
   always_comb begin
      path_in = rmcs_pkg::PATH_NONE;
      num_in  = '0;
      den_in  = '0;
      rate_in = '0;
      diff_in = '0;
      req_in  = rr_ff;
      if (!rden_nz_ff || rr_ff == '0) begin
         req_in = '0;
      end else if (exact_seen_ff) begin
         path_in = rmcs_pkg::PATH_CLOSE;
         num_in  = exact_num_ff;
         den_in  = exact_den_ff;
         rate_in = exact_rate_ff;
      end else if (close_seen) begin
         path_in = rmcs_pkg::PATH_CLOSE;
         num_in  = close_best.num;
         den_in  = close_best.den;
         rate_in = close_best.rate;
         diff_in = close_best.diff;
      end else if (wide_seen) begin
         path_in = rmcs_pkg::PATH_WIDE;
         num_in  = wide_best.num;
         den_in  = wide_best.den;
         rate_in = wide_best.rate;
         diff_in = wide_best.diff;
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a beat taken with no new one loading empties the register
         if (rsp_valid_ff && rsp_bus.ready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (div_done && div_req_done) begin
                  state_ff <= ST_TOL_CLOSE;
               end
            end
            ST_TOL_CLOSE: begin
               state_ff <= ST_TOL_WIDE;
            end
            ST_TOL_WIDE: begin
               state_ff <= ST_JUDGE;
            end
            ST_JUDGE: begin
               state_ff <= cand_last_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_path_ff  <= path_in;
                  rsp_num_ff   <= num_in;
                  rsp_den_ff   <= den_in;
                  rsp_rate_ff  <= rate_in;
                  rsp_diff_ff  <= diff_in;
                  rsp_req_ff   <= req_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // request registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_num_ff <= W'(60);
         csr_den_ff <= W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rmcs_pkg::CSR_REQ_NUM: csr_num_ff <= csr_wr_data;
            rmcs_pkg::CSR_REQ_DEN: csr_den_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // exact match flag
   always_ff @(posedge clock) begin
      if (reset || emit) begin
         exact_seen_ff <= 1'b0;
      end else if (exact_hit) begin
         exact_seen_ff <= 1'b1;
      end
   end

   // candidate datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         cand_num_ff  <= req_bus.candidate_numerator;
         cand_den_ff  <= req_bus.candidate_denominator;
         cand_last_ff <= req_bus.last_candidate;
         rden_nz_ff   <= (csr_den_ff != '0);
      end
      if (state_ff == ST_TOL_CLOSE) begin
         rr_ff        <= rr_q;
         cr_ff        <= cr_q;
         diff_ff      <= (cr_q > rr_q) ? (cr_q - rr_q) : (rr_q - cr_q);
         tol_close_ff <= (tol_raw < CLOSE_FLOOR) ? CLOSE_FLOOR : tol_raw;
      end
      if (state_ff == ST_TOL_WIDE) begin
         tol_wide_ff <= tol_raw;
      end
      if (exact_hit) begin
         exact_num_ff  <= cand_num_ff;
         exact_den_ff  <= cand_den_ff;
         exact_rate_ff <= cr_ff;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.match_path         = rsp_path_ff;
   assign rsp_bus.chosen_numerator   = rsp_num_ff;
   assign rsp_bus.chosen_denominator = rsp_den_ff;
   assign rsp_bus.chosen_rate        = rsp_rate_ff;
   assign rsp_bus.rate_difference    = rsp_diff_ff;
   assign rsp_bus.requested_rate     = rsp_req_ff;

endmodule

// ----- rtl/core/rmcs_checker.sv -----
// port-level checks of the refresh mode closest select block, bound to the top level
// depends on rmcs_pkg
module rmcs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   match_path,
   input logic [rmcs_pkg::FIELD_W-1:0] chosen_numerator,
   input logic [rmcs_pkg::FIELD_W-1:0] chosen_denominator,
   input logic [rmcs_pkg::FIELD_W-1:0] chosen_rate,
   input logic [rmcs_pkg::FIELD_W-1:0] rate_difference,
   input logic [rmcs_pkg::FIELD_W-1:0] requested_rate
);

   // a stalled result beat stays valid and keeps its path, numerator and distance
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_path)
         && $stable(chosen_numerator) && $stable(rate_difference))
      else $error("result beat changed while stalled");

   // one candidate at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while a candidate is at work");

   // no selection means an all-zero choice
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && match_path == rmcs_pkg::PATH_NONE |->
         chosen_numerator == '0 && chosen_denominator == '0
         && chosen_rate == '0 && rate_difference == '0)
      else $error("empty selection carries a mode");

   // a selection needs a valid request and a usable mode
   a_sel_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && match_path != rmcs_pkg::PATH_NONE |->
         requested_rate != '0 && chosen_denominator != '0 && chosen_rate != '0)
      else $error("selection without a valid request or mode");

   // the wide fallback lies beyond the close floor, never at distance zero
   a_wide_far: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && match_path == rmcs_pkg::PATH_WIDE |-> rate_difference != '0)
      else $error("wide fallback at zero distance");

endmodule

bind refresh_mode_closest_select rmcs_checker u_rmcs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .match_path         (rsp_bus.match_path),
   .chosen_numerator   (rsp_bus.chosen_numerator),
   .chosen_denominator (rsp_bus.chosen_denominator),
   .chosen_rate        (rsp_bus.chosen_rate),
   .rate_difference    (rsp_bus.rate_difference),
   .requested_rate     (rsp_bus.requested_rate)
);
